// File: src/spq_pkg.sv
// Package for the sorted priority queue: request/response types and codes.
`timescale 1ns / 1ps

package spq_pkg;

    localparam int VALUE_W = 32;
    localparam int IN_PRIO_W = 8;
    localparam int COUNT_W = 5;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_CLEAR  = 2'd2;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]               req_type;
        logic signed [VALUE_W-1:0] item_value;
        logic [IN_PRIO_W-1:0]     item_priority;
    } req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [VALUE_W-1:0] removed_value;
        logic signed [VALUE_W-1:0] front_value;
        logic signed [VALUE_W-1:0] rear_value;
        logic [COUNT_W-1:0]       entry_count;
    } rsp_t;

    // Per-cell control, broadcast and neighbor flags
    typedef struct packed {
        logic ins;        // accepted insert into a non-full queue
        logic rem;        // accepted remove from a non-empty queue
        logic occupied;   // this cell holds an entry
        logic at_end;     // this cell is the first free slot
        logic left_lower; // left neighbor holds a lower priority than the new entry
    } cell_ctrl_t;

endpackage

// File: src/spq_cell.sv
// One compare-and-shift cell of the sorted priority queue.
`timescale 1ns / 1ps

module spq_cell #(
    parameter int PRIO_BITS = 8
) (
    input  logic                               clk,
    input  spq_pkg::cell_ctrl_t                ctrl,
    input  logic signed [spq_pkg::VALUE_W-1:0] new_value,
    input  logic [PRIO_BITS-1:0]               new_pri,
    input  logic signed [spq_pkg::VALUE_W-1:0] left_value,
    input  logic [PRIO_BITS-1:0]               left_pri,
    input  logic signed [spq_pkg::VALUE_W-1:0] right_value,
    input  logic [PRIO_BITS-1:0]               right_pri,
    output logic signed [spq_pkg::VALUE_W-1:0] value,
    output logic [PRIO_BITS-1:0]               pri,
    output logic                               lower
);

    logic signed [spq_pkg::VALUE_W-1:0] value_reg;
    logic signed [spq_pkg::VALUE_W-1:0] value_next;
    logic [PRIO_BITS-1:0]               pri_reg;
    logic [PRIO_BITS-1:0]               pri_next;
    logic                               take_new;

    assign lower = ctrl.occupied && (pri_reg < new_pri);
    assign take_new = (lower || ctrl.at_end) && !ctrl.left_lower;

    always_comb
    begin
        value_next = value_reg;
        pri_next   = pri_reg;
        priority if (ctrl.ins && ctrl.left_lower)
        begin
            value_next = left_value;
            pri_next   = left_pri;
        end
        else if (ctrl.ins && take_new)
        begin
            value_next = new_value;
            pri_next   = new_pri;
        end
        else if (ctrl.rem)
        begin
            value_next = right_value;
            pri_next   = right_pri;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        pri_reg   <= pri_next;
    end

    assign value = value_reg;
    assign pri   = pri_reg;

endmodule

// File: src/sorted_priority_queue.sv
// Sorted priority queue built from a row of compare-and-shift cells.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------
//   req     | in        | req_valid/req_ready| spq_pkg::req_t
//   rsp     | out       | rsp_valid/rsp_ready| spq_pkg::rsp_t
//
// Every request is applied to the cell row when accepted; its response is registered and
// appears the cycle after acceptance. One request per cycle while rsp is taken.
// Reset empties the queue; cell contents are not cleared.
// A waiting response blocks new requests only when rsp_ready is low.
`timescale 1ns / 1ps

module sorted_priority_queue #(
    parameter int DEPTH = 16,
    parameter int PRIO_BITS = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  spq_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output spq_pkg::rsp_t  rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int EXT_W = (PRIO_BITS > spq_pkg::IN_PRIO_W) ? PRIO_BITS : spq_pkg::IN_PRIO_W;

    logic signed [spq_pkg::VALUE_W-1:0] cell_value [DEPTH];
    logic [PRIO_BITS-1:0]               cell_pri [DEPTH];
    logic [DEPTH-1:0]                   cell_lower;
    spq_pkg::cell_ctrl_t                cell_ctrl [DEPTH];

    logic [CNT_W-1:0]                   count_reg;
    logic [CNT_W-1:0]                   count_next;
    logic signed [spq_pkg::VALUE_W-1:0] rear_reg;
    logic signed [spq_pkg::VALUE_W-1:0] rear_next;
    logic                               rsp_valid_reg;
    logic                               rsp_valid_next;
    spq_pkg::rsp_t                      rsp_reg;
    spq_pkg::rsp_t                      rsp_next;

    logic                               accept;
    logic                               full;
    logic                               empty;
    logic                               ins_ok;
    logic                               rem_ok;
    logic                               clr;
    logic [EXT_W-1:0]                   pri_ext;
    logic [PRIO_BITS-1:0]               new_pri;
    logic signed [spq_pkg::VALUE_W-1:0] front_next;

    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign ins_ok    = accept && (req.req_type == spq_pkg::REQ_INSERT) && !full;
    assign rem_ok    = accept && (req.req_type == spq_pkg::REQ_REMOVE) && !empty;
    assign clr       = accept && (req.req_type == spq_pkg::REQ_CLEAR);

    assign pri_ext = EXT_W'(req.item_priority);
    assign new_pri = pri_ext[PRIO_BITS-1:0];

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            assign cell_ctrl[gi].ins        = ins_ok;
            assign cell_ctrl[gi].rem        = rem_ok;
            assign cell_ctrl[gi].occupied   = (CNT_W'(gi) < count_reg);
            assign cell_ctrl[gi].at_end     = (CNT_W'(gi) == count_reg);
            assign cell_ctrl[gi].left_lower = (gi == 0) ? 1'b0 : cell_lower[(gi == 0) ? 0 : gi-1];

            spq_cell #(
                .PRIO_BITS(PRIO_BITS)
            ) u_cell (
                .clk        (clk),
                .ctrl       (cell_ctrl[gi]),
                .new_value  (req.item_value),
                .new_pri    (new_pri),
                .left_value (cell_value[(gi == 0) ? 0 : gi-1]),
                .left_pri   (cell_pri[(gi == 0) ? 0 : gi-1]),
                .right_value(cell_value[(gi == DEPTH-1) ? gi : gi+1]),
                .right_pri  (cell_pri[(gi == DEPTH-1) ? gi : gi+1]),
                .value      (cell_value[gi]),
                .pri        (cell_pri[gi]),
                .lower      (cell_lower[gi])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        rear_next  = rear_reg;
        front_next = cell_value[0];
        priority if (ins_ok)
        begin
            count_next = count_reg + CNT_W'(1);
            // no lower entry means the new one lands at the rear
            if (!(|cell_lower))
            begin
                rear_next = req.item_value;
            end
            if (cell_lower[0] || empty)
            begin
                front_next = req.item_value;
            end
        end
        else if (rem_ok)
        begin
            count_next = count_reg - CNT_W'(1);
            front_next = cell_value[1];
        end
        else if (clr)
        begin
            count_next = '0;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (accept)
        begin
            rsp_valid_next = 1'b1;
            rsp_next.status = spq_pkg::STAT_OK;
            if ((req.req_type == spq_pkg::REQ_INSERT) && full)
            begin
                rsp_next.status = spq_pkg::STAT_FULL;
            end
            if ((req.req_type == spq_pkg::REQ_REMOVE) && empty)
            begin
                rsp_next.status = spq_pkg::STAT_EMPTY;
            end
            rsp_next.removed_value = rem_ok ? cell_value[0] : '0;
            rsp_next.front_value   = (count_next == '0) ? '0 : front_next;
            rsp_next.rear_value    = (count_next == '0) ? '0 : rear_next;
            rsp_next.entry_count   = spq_pkg::COUNT_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rear_reg <= rear_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// File: sim/sorted_priority_queue_tb.sv
// Testbench for the sorted priority queue: directed and random requests against a queue model.
`timescale 1ns / 1ps

module sorted_priority_queue_tb;

    localparam int DEPTH = 16;
    localparam int PRIO_BITS = 8;
    localparam logic [1:0] REQ_NOP = 2'd3;    // unused code, acts as a no-op
    localparam int QUIET_LIMIT = 1000;
    localparam int HOLD_CYCLES = 120;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    spq_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    spq_pkg::rsp_t rsp;

    // Shadow of the cell row: index 0 is the front
    logic signed [spq_pkg::VALUE_W-1:0] shadow_value [DEPTH];
    logic [PRIO_BITS-1:0]               shadow_prio [DEPTH];
    int shadow_count = 0;

    spq_pkg::rsp_t pending_rsp [$];
    int errors = 0;
    bit idle_on = 1'b1;
    int hold_request = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int n_req = 0;
    int n_ins = 0;
    int n_rem = 0;
    int n_full = 0;
    int n_empty = 0;
    int max_fill = 0;

    always #1 clk = ~clk;

    sorted_priority_queue #(
        .DEPTH(DEPTH),
        .PRIO_BITS(PRIO_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp)
    );

    // Applies one request to the shadow queue and returns the response it should give.
    function automatic spq_pkg::rsp_t queue_step(spq_pkg::req_t r);
        spq_pkg::rsp_t o;
        int pos;
        logic [PRIO_BITS-1:0] pri;
        o = '0;
        o.status = spq_pkg::STAT_OK;
        pri = r.item_priority[PRIO_BITS-1:0];
        case (r.req_type)
            spq_pkg::REQ_INSERT:
            begin
                if (shadow_count >= DEPTH)
                    o.status = spq_pkg::STAT_FULL;
                else
                begin
                    // new entry goes behind everything of equal or higher priority
                    pos = shadow_count;
                    while (pos > 0 && shadow_prio[pos-1] < pri)
                    begin
                        shadow_value[pos] = shadow_value[pos-1];
                        shadow_prio[pos] = shadow_prio[pos-1];
                        pos--;
                    end
                    shadow_value[pos] = r.item_value;
                    shadow_prio[pos] = pri;
                    shadow_count++;
                end
            end
            spq_pkg::REQ_REMOVE:
            begin
                if (shadow_count == 0)
                    o.status = spq_pkg::STAT_EMPTY;
                else
                begin
                    o.removed_value = shadow_value[0];
                    for (int k = 1; k < shadow_count; k++)
                    begin
                        shadow_value[k-1] = shadow_value[k];
                        shadow_prio[k-1] = shadow_prio[k];
                    end
                    shadow_count--;
                end
            end
            spq_pkg::REQ_CLEAR:
                shadow_count = 0;
            default:
                ;
        endcase
        if (shadow_count > 0)
        begin
            o.front_value = shadow_value[0];
            o.rear_value = shadow_value[shadow_count-1];
        end
        o.entry_count = shadow_count[spq_pkg::COUNT_W-1:0];
        return o;
    endfunction

    function automatic spq_pkg::req_t make_request(logic [1:0] kind,
                                                   logic [spq_pkg::VALUE_W-1:0] value,
                                                   logic [spq_pkg::IN_PRIO_W-1:0] prio);
        spq_pkg::req_t r;
        r.req_type = kind;
        r.item_value = value;
        r.item_priority = prio;
        return r;
    endfunction

    function automatic spq_pkg::req_t rand_request(int ins_pct);
        spq_pkg::req_t r;
        int roll;
        roll = $urandom_range(99);
        if ($urandom_range(7) == 0)
            r.item_value = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
        else
            r.item_value = $urandom;
        case ($urandom_range(3))
            0: r.item_priority = 8'($urandom_range(3));    // narrow range forces ties
            1: r.item_priority = $urandom_range(1) ? 8'hff : 8'h00;
            default: r.item_priority = 8'($urandom);
        endcase
        if (roll < ins_pct)
            r.req_type = spq_pkg::REQ_INSERT;
        else if (roll < 96)
            r.req_type = spq_pkg::REQ_REMOVE;
        else if (roll < 98)
            r.req_type = spq_pkg::REQ_CLEAR;
        else
            r.req_type = REQ_NOP;
        return r;
    endfunction

    // Called right after a rising edge; returns right after one too.
    task automatic send_request(input spq_pkg::req_t r);
        spq_pkg::rsp_t want;
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        want = queue_step(r);
        pending_rsp.push_back(want);
        n_req++;
        if (r.req_type == spq_pkg::REQ_INSERT)
            n_ins++;
        if (r.req_type == spq_pkg::REQ_REMOVE)
            n_rem++;
        if (want.status == spq_pkg::STAT_FULL)
            n_full++;
        if (want.status == spq_pkg::STAT_EMPTY)
            n_empty++;
        if (shadow_count > max_fill)
            max_fill = shadow_count;
        if (idle_on && $urandom_range(99) < 15)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(3, 1))
                @(posedge clk);
        end
    endtask

    task automatic test_directed;
        send_request(make_request(spq_pkg::REQ_REMOVE, 32'h0000_0005, 8'd9));    // remove on empty
        send_request(make_request(spq_pkg::REQ_CLEAR, 32'hffff_ffff, 8'hff));
        send_request(make_request(REQ_NOP, 32'h1234_5678, 8'h55));
        send_request(make_request(spq_pkg::REQ_INSERT, 32'h7fff_ffff, 8'hff));
        send_request(make_request(spq_pkg::REQ_INSERT, 32'h8000_0000, 8'h00));
        send_request(make_request(spq_pkg::REQ_INSERT, 32'h0000_0000, 8'h80));
        send_request(make_request(spq_pkg::REQ_INSERT, 32'hffff_ffff, 8'h80)); // equal priority, FIFO
        send_request(make_request(spq_pkg::REQ_INSERT, 32'h0000_0001, 8'hff));
        send_request(make_request(spq_pkg::REQ_INSERT, 32'h0000_0002, 8'h00));
        send_request(make_request(REQ_NOP, 32'hdead_beef, 8'h01));
        send_request(make_request(spq_pkg::REQ_REMOVE, 32'h0, 8'h0));
        send_request(make_request(spq_pkg::REQ_REMOVE, 32'h0, 8'h0));
        send_request(make_request(spq_pkg::REQ_CLEAR, 32'h0, 8'h0));
        send_request(make_request(spq_pkg::REQ_REMOVE, 32'h0, 8'h0));
    endtask

    task automatic test_full;
        for (int i = 0; i < DEPTH; i++)
            send_request(make_request(spq_pkg::REQ_INSERT, 32'h100 + i, 8'(i % 3)));
        send_request(make_request(spq_pkg::REQ_INSERT, 32'h7fff_ffff, 8'hff));    // rejected
        send_request(make_request(spq_pkg::REQ_INSERT, 32'h8000_0000, 8'h00));    // rejected
        send_request(make_request(spq_pkg::REQ_REMOVE, 32'h0, 8'h0));
        send_request(make_request(spq_pkg::REQ_INSERT, 32'h0000_0abc, 8'hff));
        send_request(make_request(spq_pkg::REQ_CLEAR, 32'h0, 8'h0));
    endtask

    // Insert share is redrawn every 40 requests so the fill level sweeps empty to full.
    task automatic test_random(input int count);
        int bias;
        bias = 50;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
            begin
                case ($urandom_range(2))
                    0: bias = 25;
                    1: bias = 50;
                    default: bias = 85;
                endcase
            end
            send_request(rand_request(bias));
        end
    endtask

    task automatic test_backpressure;
        hold_request = HOLD_CYCLES;
        repeat (40)
            send_request(rand_request(60));
    endtask

    task automatic test_no_idle;
        idle_on = 1'b0;
        test_random(300);
        idle_on = 1'b1;
    endtask

    // Response side: random stalls, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
        end
        else if (hold_request > 0)
        begin
            hold_left <= hold_request - 1;
            hold_request = 0;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= !(idle_on && $urandom_range(99) < 15);
    end

    always @(posedge clk)
    begin : rsp_check
        spq_pkg::rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("response with none pending: %p", rsp);
                errors++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp.status);
                    errors++;
                end
                if (rsp.removed_value !== want.removed_value)
                begin
                    $error("removed_value: expected %0d, got %0d",
                           want.removed_value, rsp.removed_value);
                    errors++;
                end
                if (rsp.front_value !== want.front_value)
                begin
                    $error("front_value: expected %0d, got %0d",
                           want.front_value, rsp.front_value);
                    errors++;
                end
                if (rsp.rear_value !== want.rear_value)
                begin
                    $error("rear_value: expected %0d, got %0d",
                           want.rear_value, rsp.rear_value);
                    errors++;
                end
                if (rsp.entry_count !== want.entry_count)
                begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, rsp.entry_count);
                    errors++;
                end
            end
        end
    end

    // Watchdog: ends the run when neither side has moved for too long
    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed;
        test_full;
        test_random(1250);
        test_backpressure;
        test_no_idle;
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
        $display("Ran %0d requests: %0d inserts (%0d refused full), %0d removes (%0d on empty).",
                 n_req, n_ins, n_full, n_rem, n_empty);
        $display("Fill reached %0d of %0d; one %0d-cycle response hold-off, one idle-free burst.",
                 max_fill, DEPTH, HOLD_CYCLES);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
